[hw/rtl/itcq_pkg.sv]
`default_nettype none

package itcq_pkg;

   // operation codes of the request word
   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_REFRESH = 3'd2,
      OP_CHECK   = 3'd3,
      OP_LOOKUP  = 3'd4
   } itcq_op_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_PRESENT   = 2'd3
   } itcq_status_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_FIND,
      S_DECIDE,
      S_NEXT_RD,
      S_NEXT_WAIT,
      S_PRED,
      S_UNLINK_WR,
      S_UNLINK_FIN,
      S_APPEND,
      S_HEAD_RD,
      S_HEAD_CMP,
      S_DONE
   } itcq_state_type;

   // per-array write enables into the entry store
   typedef struct packed {
      logic sock;
      logic stamp;
      logic link;
      logic valid;
   } itcq_we_type;

   localparam logic [31:0] TIMEOUT_RESET = 32'd10;

endpackage

`default_nettype wire

[hw/rtl/idle_timeout_client_queue_core.sv]
`default_nettype none

// Idle-timeout connection queue. Holds up to DEPTH sockets in a singly linked
// order of last activity, oldest at the head. A request word is taken when
// start is high and busy is low; exactly one response word follows, shown for
// one cycle with rsp_strobe high. The receiver cannot stall: sample the
// response in the strobe cycle. All reads go through one memory read port that
// walks one slot per cycle:
//   add, lookup        : a scan for the socket
//   remove, refresh    : a socket scan, then, unless the slot is the head, a scan
//                        for the predecessor slot
//   check timeout      : head only; no read on an empty queue
//   unknown opcode     : no read
// After reset the valid store is cleared, one slot at a time, with busy high.
// The timeout register may be written on csr_* whenever the block is idle.

module idle_timeout_client_queue_core import itcq_pkg::*; #(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // request
   input  wire logic          start,
   output logic               busy,
   input  wire logic [2:0]    req_operation,
   input  wire logic [15:0]   req_socket_id,
   input  wire logic [31:0]   req_now_seconds,
   // response
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic               rsp_hit,
   output logic [15:0]        rsp_socket_out,
   output logic [CW-1:0]      rsp_occupancy,
   // timeout register
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [31:0]   csr_data
);

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   itcq_state_type state_ff, state_in;

   // control state
   logic [AW-1:0] scan_ff, scan_in;          // scan address being issued
   logic          cmp_live_ff, cmp_live_in;  // read data belongs to scan
   logic          found_ff, found_in;
   logic          free_found_ff, free_found_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   timeout_ff, timeout_in;

   // payload
   logic [2:0]    op_ff, op_in;
   logic [15:0]   sock_ff, sock_in;
   logic [31:0]   now_ff, now_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;   // slot of the data now on rd_*
   logic [AW-1:0] slot_ff, slot_in;         // slot being worked on
   logic [AW-1:0] free_ff, free_in;         // lowest free slot
   logic [AW-1:0] next_ff, next_in;         // link of the slot being unlinked
   logic [AW-1:0] prev_ff, prev_in;         // its predecessor
   logic [1:0]    res_status_ff, res_status_in;
   logic          res_hit_ff, res_hit_in;
   logic [15:0]   res_sock_ff, res_sock_in;

   // store interface
   itcq_we_type   we;
   logic [AW-1:0] wr_slot;
   logic          valid_wdata;
   logic [AW-1:0] link_waddr;
   logic [AW-1:0] link_wdata;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rd_socket;
   logic [31:0]   rd_stamp;
   logic [AW-1:0] rd_link;
   logic          rd_valid;
   logic [AW-1:0] scan_step;
   logic [31:0]   idle_age;

   itcq_store #(.DEPTH(DEPTH)) u_store (
      .clock       (clock),
      .we          (we),
      .slot_addr   (wr_slot),
      .sock_wdata  (sock_ff),
      .stamp_wdata (now_ff),
      .valid_wdata (valid_wdata),
      .link_waddr  (link_waddr),
      .link_wdata  (link_wdata),
      .rd_addr     (rd_addr),
      .rd_socket   (rd_socket),
      .rd_stamp    (rd_stamp),
      .rd_link     (rd_link),
      .rd_valid    (rd_valid)
   );

   // scan address holds at the last slot
   assign scan_step = (scan_ff == LAST) ? scan_ff : scan_ff + 1'b1;
   // idle time of the head, wraps mod 2^32
   assign idle_age = now_ff - rd_stamp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         scan_ff       <= '0;
         cmp_live_ff   <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         timeout_ff    <= TIMEOUT_RESET;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         cmp_live_ff   <= cmp_live_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         timeout_ff    <= timeout_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      sock_ff       <= sock_in;
      now_ff        <= now_in;
      cmp_idx_ff    <= cmp_idx_in;
      slot_ff       <= slot_in;
      free_ff       <= free_in;
      next_ff       <= next_in;
      prev_ff       <= prev_in;
      res_status_ff <= res_status_in;
      res_hit_ff    <= res_hit_in;
      res_sock_ff   <= res_sock_in;
   end

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      cmp_live_in   = cmp_live_ff;
      found_in      = found_ff;
      free_found_in = free_found_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      timeout_in    = timeout_ff;
      op_in         = op_ff;
      sock_in       = sock_ff;
      now_in        = now_ff;
      cmp_idx_in    = cmp_idx_ff;
      slot_in       = slot_ff;
      free_in       = free_ff;
      next_in       = next_ff;
      prev_in       = prev_ff;
      res_status_in = res_status_ff;
      res_hit_in    = res_hit_ff;
      res_sock_in   = res_sock_ff;

      we          = '0;
      wr_slot     = slot_ff;
      valid_wdata = 1'b0;
      link_waddr  = prev_ff;
      link_wdata  = next_ff;
      rd_addr     = scan_ff;

      if (csr_valid) begin
         timeout_in = csr_data;
      end

      case (state_ff)
         S_CLEAR: begin
            // one valid bit per cycle after reset
            we.valid = 1'b1;
            wr_slot  = scan_ff;
            scan_in  = scan_step;
            if (scan_ff == LAST) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               op_in         = req_operation;
               sock_in       = req_socket_id;
               now_in        = req_now_seconds;
               res_status_in = ST_OK;
               res_hit_in    = 1'b0;
               res_sock_in   = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               scan_in       = '0;
               cmp_live_in   = 1'b0;
               case (req_operation)
                  OP_ADD, OP_REMOVE, OP_REFRESH, OP_LOOKUP: begin
                     state_in = S_FIND;
                  end
                  OP_CHECK: begin
                     state_in = (count_ff != '0) ? S_HEAD_RD : S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_FIND: begin
            // pipelined scan: issue one slot, compare the one before
            scan_in     = scan_step;
            cmp_live_in = 1'b1;
            cmp_idx_in  = scan_ff;
            if (cmp_live_ff) begin
               if (rd_valid && rd_socket == sock_ff) begin
                  found_in = 1'b1;
                  slot_in  = cmp_idx_ff;
                  state_in = S_DECIDE;
               end else begin
                  if (!rd_valid && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_in       = cmp_idx_ff;
                  end
                  if (cmp_idx_ff == LAST) begin
                     state_in = S_DECIDE;
                  end
               end
            end
         end

         S_DECIDE: begin
            case (op_ff)
               OP_ADD: begin
                  if (found_ff) begin
                     res_status_in = ST_PRESENT;
                     state_in      = S_DONE;
                  end else if (count_ff == FULL_COUNT || !free_found_ff) begin
                     res_status_in = ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     slot_in  = free_ff;
                     state_in = S_APPEND;
                  end
               end
               OP_REMOVE, OP_REFRESH: begin
                  if (found_ff) begin
                     state_in = S_NEXT_RD;
                  end else begin
                     res_status_in = ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end
               end
               OP_LOOKUP: begin
                  res_sock_in = sock_ff;
                  if (found_ff) begin
                     res_hit_in = 1'b1;
                  end else begin
                     res_status_in = ST_NOT_FOUND;
                  end
                  state_in = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_NEXT_RD: begin
            rd_addr  = slot_ff;
            state_in = S_NEXT_WAIT;
         end

         S_NEXT_WAIT: begin
            next_in = rd_link;
            if (slot_ff == head_ff) begin
               head_in  = rd_link;
               state_in = S_UNLINK_FIN;
            end else begin
               scan_in     = '0;
               cmp_live_in = 1'b0;
               state_in    = S_PRED;
            end
         end

         S_PRED: begin
            // predecessor: the valid non-tail slot linking to this one
            scan_in     = scan_step;
            cmp_live_in = 1'b1;
            cmp_idx_in  = scan_ff;
            if (cmp_live_ff) begin
               if (rd_valid && rd_link == slot_ff && cmp_idx_ff != tail_ff) begin
                  prev_in  = cmp_idx_ff;
                  state_in = S_UNLINK_WR;
               end else if (cmp_idx_ff == LAST) begin
                  state_in = S_UNLINK_FIN;
               end
            end
         end

         S_UNLINK_WR: begin
            we.link = 1'b1;
            if (tail_ff == slot_ff) begin
               tail_in = prev_ff;
            end
            state_in = S_UNLINK_FIN;
         end

         S_UNLINK_FIN: begin
            we.valid = 1'b1;
            count_in = count_ff - 1'b1;
            if (count_ff == CW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end
            state_in = (op_ff == OP_REFRESH) ? S_APPEND : S_DONE;
         end

         S_APPEND: begin
            we.stamp    = 1'b1;
            we.valid    = 1'b1;
            valid_wdata = 1'b1;
            we.sock     = (op_ff == OP_ADD);
            if (count_ff == '0) begin
               head_in = slot_ff;
            end else begin
               we.link    = 1'b1;
               link_waddr = tail_ff;
               link_wdata = slot_ff;
            end
            tail_in  = slot_ff;
            count_in = count_ff + 1'b1;
            state_in = S_DONE;
         end

         S_HEAD_RD: begin
            rd_addr  = head_ff;
            state_in = S_HEAD_CMP;
         end

         S_HEAD_CMP: begin
            if (idle_age > timeout_ff) begin
               res_hit_in  = 1'b1;
               res_sock_in = rd_socket;
               slot_in     = head_ff;
               state_in    = S_NEXT_RD;
            end else begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_strobe     = (state_ff == S_DONE);
   assign rsp_status     = res_status_ff;
   assign rsp_hit        = res_hit_ff;
   assign rsp_socket_out = res_sock_ff;
   assign rsp_occupancy  = count_ff;

endmodule

`default_nettype wire

[hw/rtl/itcq_store.sv]
`default_nettype none

module itcq_store import itcq_pkg::*; #(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire itcq_we_type   we,
   input  wire logic [AW-1:0] slot_addr,
   input  wire logic [15:0]   sock_wdata,
   input  wire logic [31:0]   stamp_wdata,
   input  wire logic          valid_wdata,
   input  wire logic [AW-1:0] link_waddr,
   input  wire logic [AW-1:0] link_wdata,
   input  wire logic [AW-1:0] rd_addr,
   output logic [15:0]        rd_socket,
   output logic [31:0]        rd_stamp,
   output logic [AW-1:0]      rd_link,
   output logic               rd_valid
);

   logic [15:0]   sock_mem  [DEPTH];
   logic [31:0]   stamp_mem [DEPTH];
   logic [AW-1:0] link_mem  [DEPTH];
   logic          valid_mem [DEPTH];

   logic [15:0]   rd_socket_ff;
   logic [31:0]   rd_stamp_ff;
   logic [AW-1:0] rd_link_ff;
   logic          rd_valid_ff;

   always_ff @(posedge clock) begin
      if (we.sock) begin
         sock_mem[slot_addr] <= sock_wdata;
      end
      if (we.stamp) begin
         stamp_mem[slot_addr] <= stamp_wdata;
      end
      if (we.valid) begin
         valid_mem[slot_addr] <= valid_wdata;
      end
      if (we.link) begin
         link_mem[link_waddr] <= link_wdata;
      end
   end

   // one shared read address, registered data
   always_ff @(posedge clock) begin
      rd_socket_ff <= sock_mem[rd_addr];
      rd_stamp_ff  <= stamp_mem[rd_addr];
      rd_link_ff   <= link_mem[rd_addr];
      rd_valid_ff  <= valid_mem[rd_addr];
   end

   assign rd_socket = rd_socket_ff;
   assign rd_stamp  = rd_stamp_ff;
   assign rd_link   = rd_link_ff;
   assign rd_valid  = rd_valid_ff;

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import itcq_pkg::*;

   localparam int DEPTH = 64;
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int POOL = 96;          // sockets drawn for most words
   localparam int CHUNKS = 6;         // timeout settings in the random part
   localparam int CHUNK_WORDS = 238;
   localparam int LIMIT = 1_500_000;  // cycles before the watchdog fires

   // opcodes outside the defined set; the block must treat them as no-ops
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   // one response word, as the block presents it
   typedef struct packed {
      itcq_status_type   status;
      logic              hit;
      logic [15:0]       sock;
      logic [OCC_W-1:0]  occ;
   } conn_rsp_type;

   // directed row; fixed rows carry a hand-written response
   typedef struct packed {
      logic [2:0]   op;
      logic [15:0]  sock;
      logic [31:0]  now;
      logic         fixed;
      conn_rsp_type rsp;
   } stim_row_type;

   localparam conn_rsp_type NO_RSP = '0;
   localparam int DIR_ROWS = 25;

   // Directed opening at the reset timeout of 10 s: empty-queue misses,
   // extreme sockets and stamps, duplicate add, the expiry boundary (age
   // equal to the limit does not expire, one more does, also across the
   // 2^32 wrap), spare opcodes, middle and tail unlink, a refresh that
   // moves the oldest to the tail, draining to empty and reuse of slot 0.
   localparam stim_row_type DIR_STIM [DIR_ROWS] = '{
      '{OP_CHECK,    16'h0000, 32'd0,          1'b1, '{ST_OK,        1'b0, 16'h0000, 7'd0}},
      '{OP_LOOKUP,   16'hFFFF, 32'd0,          1'b1, '{ST_NOT_FOUND, 1'b0, 16'hFFFF, 7'd0}},
      '{OP_REMOVE,   16'h0005, 32'd0,          1'b1, '{ST_NOT_FOUND, 1'b0, 16'h0000, 7'd0}},
      '{OP_REFRESH,  16'h0005, 32'd0,          1'b1, '{ST_NOT_FOUND, 1'b0, 16'h0000, 7'd0}},
      '{OP_ADD,      16'h0000, 32'd0,          1'b1, '{ST_OK,        1'b0, 16'h0000, 7'd1}},
      '{OP_ADD,      16'hFFFF, 32'hFFFF_FFFF,  1'b1, '{ST_OK,        1'b0, 16'h0000, 7'd2}},
      '{OP_ADD,      16'h0000, 32'd5,          1'b1, '{ST_PRESENT,   1'b0, 16'h0000, 7'd2}},
      '{OP_LOOKUP,   16'h0000, 32'd5,          1'b1, '{ST_OK,        1'b1, 16'h0000, 7'd2}},
      '{OP_CHECK,    16'h0000, 32'd10,         1'b1, '{ST_OK,        1'b0, 16'h0000, 7'd2}},
      '{OP_CHECK,    16'hA5A5, 32'd11,         1'b1, '{ST_OK,        1'b1, 16'h0000, 7'd1}},
      '{OP_CHECK,    16'h0000, 32'd9,          1'b1, '{ST_OK,        1'b0, 16'h0000, 7'd1}},
      '{OP_SPARE_LO, 16'h0000, 32'd9,          1'b1, '{ST_OK,        1'b0, 16'h0000, 7'd1}},
      '{OP_SPARE_HI, 16'hFFFF, 32'hFFFF_FFFF,  1'b1, '{ST_OK,        1'b0, 16'h0000, 7'd1}},
      '{OP_ADD,      16'h1234, 32'd100,        1'b0, NO_RSP},
      '{OP_ADD,      16'h0001, 32'd101,        1'b0, NO_RSP},
      '{OP_ADD,      16'h8000, 32'd102,        1'b0, NO_RSP},
      '{OP_REFRESH,  16'hFFFF, 32'd200,        1'b0, NO_RSP},
      '{OP_REMOVE,   16'h0001, 32'd201,        1'b0, NO_RSP},
      '{OP_REMOVE,   16'hFFFF, 32'd202,        1'b0, NO_RSP},
      '{OP_LOOKUP,   16'h0001, 32'd203,        1'b1, '{ST_NOT_FOUND, 1'b0, 16'h0001, 7'd2}},
      '{OP_CHECK,    16'h0000, 32'd300,        1'b0, NO_RSP},
      '{OP_REMOVE,   16'h8000, 32'd300,        1'b0, NO_RSP},
      '{OP_ADD,      16'h4321, 32'd301,        1'b0, NO_RSP},
      '{OP_CHECK,    16'h0000, 32'd0,          1'b0, NO_RSP},
      '{OP_CHECK,    16'h0000, 32'd0,          1'b1, '{ST_OK,        1'b0, 16'h0000, 7'd0}}
   };

   // ---------------------------------------------------------------------
   // DUT ports; every input is known from time zero
   // ---------------------------------------------------------------------
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [2:0]        req_operation = '0;
   logic [15:0]       req_socket_id = '0;
   logic [31:0]       req_now_seconds = '0;
   logic              rsp_strobe;
   logic [1:0]        rsp_status;
   logic              rsp_hit;
   logic [15:0]       rsp_socket_out;
   logic [OCC_W-1:0]  rsp_occupancy;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [31:0]       csr_data = '0;

   idle_timeout_client_queue_core #(.DEPTH(DEPTH)) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_socket_id   (req_socket_id),
      .req_now_seconds (req_now_seconds),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_hit         (rsp_hit),
      .rsp_socket_out  (rsp_socket_out),
      .rsp_occupancy   (rsp_occupancy),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: our own copy of the linked idle order
   // ---------------------------------------------------------------------
   logic [15:0]  conn_sock  [DEPTH];
   logic [31:0]  conn_stamp [DEPTH];
   logic [5:0]   conn_next  [DEPTH];
   bit           conn_live  [DEPTH];
   logic [5:0]   oldest_slot;
   logic [5:0]   newest_slot;
   int           conn_count;
   logic [31:0]  idle_limit;

   conn_rsp_type due_rsp [$];   // response words still owed by the block
   int           fail_count = 0;

   // run statistics for the summary
   int           op_count [8];
   int           full_seen;
   int           expired_seen;

   function automatic int find_conn(logic [15:0] sock);
      int i;
      for (i = 0; i < DEPTH; i++) begin
         if (conn_live[i] && conn_sock[i] == sock) return i;
      end
      return DEPTH;
   endfunction

   function automatic void append_conn(int slot, logic [31:0] now);
      conn_stamp[slot] = now;
      conn_live[slot]  = 1'b1;
      if (conn_count == 0) oldest_slot = 6'(slot);
      else conn_next[newest_slot] = 6'(slot);
      newest_slot = 6'(slot);
      conn_count++;
   endfunction

   // walk from the head for the predecessor
   function automatic void unlink_conn(int slot);
      int prev;
      int steps;
      if (slot == oldest_slot) begin
         oldest_slot = conn_next[slot];
      end else begin
         prev = oldest_slot;
         for (steps = 0; steps < conn_count; steps++) begin
            if (conn_next[prev] == slot) begin
               conn_next[prev] = conn_next[slot];
               if (newest_slot == slot) newest_slot = 6'(prev);
               break;
            end
            prev = conn_next[prev];
         end
      end
      conn_live[slot] = 1'b0;
      conn_count--;
      if (conn_count == 0) begin
         oldest_slot = '0;
         newest_slot = '0;
      end
   endfunction

   function automatic conn_rsp_type conn_queue_step(logic [2:0] op, logic [15:0] sock,
                                                    logic [31:0] now);
      conn_rsp_type r;
      int           slot;
      logic [31:0]  age;
      r = NO_RSP;
      case (op)
         OP_ADD: begin
            if (find_conn(sock) < DEPTH) begin
               r.status = ST_PRESENT;
            end else if (conn_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // lowest free slot
               slot = 0;
               while (conn_live[slot]) slot++;
               conn_sock[slot] = sock;
               append_conn(slot, now);
            end
         end
         OP_REMOVE, OP_REFRESH: begin
            slot = find_conn(sock);
            if (slot >= DEPTH) begin
               r.status = ST_NOT_FOUND;
            end else begin
               unlink_conn(slot);
               if (op == OP_REFRESH) append_conn(slot, now);
            end
         end
         OP_CHECK: begin
            // only the head is examined; age wraps mod 2^32
            if (conn_count > 0 && conn_live[oldest_slot]) begin
               slot = oldest_slot;
               age = now - conn_stamp[slot];
               if (age > idle_limit) begin
                  r.hit  = 1'b1;
                  r.sock = conn_sock[slot];
                  unlink_conn(slot);
               end
            end
         end
         OP_LOOKUP: begin
            r.sock = sock;
            if (find_conn(sock) < DEPTH) r.hit = 1'b1;
            else r.status = ST_NOT_FOUND;
         end
         default: ;
      endcase
      r.occ = conn_count[OCC_W-1:0];
      return r;
   endfunction

   // socket of some held connection; only called with conn_count > 0
   function automatic logic [15:0] pick_live_sock();
      int slot;
      slot = $urandom_range(DEPTH - 1);
      while (!conn_live[slot]) slot = (slot + 1) % DEPTH;
      return conn_sock[slot];
   endfunction

   // cycles the sender stays quiet after a word; long ones land deep in a walk
   function automatic int pick_gap(int idle_pct);
      if ($urandom_range(99) >= idle_pct) return 0;
      if ($urandom_range(3) == 0) return $urandom_range(5, 150);
      return $urandom_range(1, 4);
   endfunction

   // ---------------------------------------------------------------------
   // Response checker: strobe marks a one-cycle word, no back-pressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      conn_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (due_rsp.size() == 0) begin
            $error("response word with nothing outstanding: status %0d sock %h",
                   rsp_status, rsp_socket_out);
            fail_count++;
         end else begin
            want = due_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
               fail_count++;
            end
            if (rsp_socket_out !== want.sock) begin
               $error("socket_out: expected %h, got %h", want.sock, rsp_socket_out);
               fail_count++;
            end
            if (rsp_occupancy !== want.occ) begin
               $error("occupancy: expected %0d, got %0d", want.occ, rsp_occupancy);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words outstanding", LIMIT, due_rsp.size());
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Present one request word and hold it until taken (start & !busy at an
   // edge). The expectation is logged at that edge. With gap 0, start stays
   // high so the caller's next word follows without a bubble; a nonzero gap
   // drops start here, so it is never lowered and raised in one step.
   task automatic issue_word(input logic [2:0] op, input logic [15:0] sock,
                             input logic [31:0] now, input int gap,
                             input bit fixed, input conn_rsp_type fixed_rsp);
      conn_rsp_type pred;
      req_operation   <= op;
      req_socket_id   <= sock;
      req_now_seconds <= now;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pred = conn_queue_step(op, sock, now);
      due_rsp.push_back(fixed ? fixed_rsp : pred);
      op_count[op]++;
      if (pred.status == ST_FULL) full_seen++;
      if (op == OP_CHECK && pred.hit) expired_seen++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every owed word has come back and the block is idle
   task automatic wait_drained();
      while (due_rsp.size() != 0 || busy) @(posedge clock);
   endtask

   // timeout register write, only with the block idle
   task automatic set_timeout(input logic [31:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      idle_limit = value;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [15:0] sock_pool [POOL];
      logic [31:0] limit_plan [CHUNKS];
      int          idle_plan  [CHUNKS];
      logic [31:0] wall_now;
      logic [2:0]  op;
      logic [15:0] sock;
      bit          filling;
      bit          pause;
      int          full_dwell;
      int          drain_floor;
      int          gap;
      int          roll;
      int          i;
      int          chunk;
      int          n;

      for (i = 0; i < POOL; i++) sock_pool[i] = 16'($urandom_range(16'hFFFF));
      for (i = 0; i < 8; i++) op_count[i] = 0;
      full_seen    = 0;
      expired_seen = 0;

      // model after reset
      for (i = 0; i < DEPTH; i++) begin
         conn_sock[i]  = '0;
         conn_stamp[i] = '0;
         conn_next[i]  = '0;
         conn_live[i]  = 1'b0;
      end
      oldest_slot = '0;
      newest_slot = '0;
      conn_count  = 0;
      idle_limit  = TIMEOUT_RESET;

      // timeout per random chunk: zero, the ceiling, a small random one,
      // one, fully random, back to the reset value
      limit_plan = '{32'd0, 32'hFFFF_FFFF, $urandom_range(3, 40), 32'd1, $urandom(),
                     TIMEOUT_RESET};
      // sender idle share: 30 %, then 57 %, then back to back
      idle_plan  = '{30, 30, 57, 57, 0, 0};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset timeout; the block's clearing pass after
      // reset is covered by waiting for busy
      for (i = 0; i < DIR_ROWS; i++) begin
         gap = (i == DIR_ROWS - 1) ? 1 : pick_gap(50);
         issue_word(DIR_STIM[i].op, DIR_STIM[i].sock, DIR_STIM[i].now, gap,
                    DIR_STIM[i].fixed, DIR_STIM[i].rsp);
      end

      // Random part. The mix swings between filling the table up to full
      // (and sitting there to draw full and duplicate refusals) and
      // draining it down, often to empty. Most sockets come from a fixed
      // pool or from what is held, so hits, middle unlinks and refreshes
      // are common; a few are stray sockets, spare opcodes or jumps of the
      // clock to a random second, which also crosses the 2^32 wrap.
      wall_now    = 32'd1000;
      filling     = 1'b1;
      full_dwell  = 0;
      drain_floor = 0;
      for (chunk = 0; chunk < CHUNKS; chunk++) begin
         set_timeout(limit_plan[chunk]);
         for (n = 0; n < CHUNK_WORDS; n++) begin
            if (filling && conn_count == DEPTH) begin
               full_dwell++;
               if (full_dwell > 6) begin
                  filling     = 1'b0;
                  drain_floor = $urandom_range(1) ? 0 : $urandom_range(1, 24);
               end
            end else if (!filling && conn_count <= drain_floor) begin
               filling    = 1'b1;
               full_dwell = 0;
            end

            roll = $urandom_range(99);
            if (filling) begin
               if (roll < 60)      op = OP_ADD;
               else if (roll < 70) op = OP_LOOKUP;
               else if (roll < 78) op = OP_REFRESH;
               else if (roll < 85) op = OP_REMOVE;
               else if (roll < 95) op = OP_CHECK;
               else                op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            end else begin
               if (roll < 15)      op = OP_ADD;
               else if (roll < 30) op = OP_LOOKUP;
               else if (roll < 40) op = OP_REFRESH;
               else if (roll < 70) op = OP_REMOVE;
               else if (roll < 95) op = OP_CHECK;
               else                op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            end

            roll = $urandom_range(99);
            if (roll < 5) sock = 16'($urandom_range(16'hFFFF));
            else if (op != OP_ADD && roll < 70 && conn_count != 0) sock = pick_live_sock();
            else sock = sock_pool[$urandom_range(POOL - 1)];

            if ($urandom_range(49) == 0) wall_now = $urandom();
            else wall_now += filling ? $urandom_range(0, 2) : $urandom_range(0, 8);

            // now and then the sender waits for the block to go quiet
            pause = ($urandom_range(59) == 0) || (n == CHUNK_WORDS - 1);
            gap = pick_gap(idle_plan[chunk]);
            if (pause && gap == 0) gap = 1;
            issue_word(op, sock, wall_now, gap, 1'b0, NO_RSP);
            if (pause) wait_drained();
         end
      end

      // let any stray word show up before closing
      wait_drained();
      repeat (2 * DEPTH + 16) @(posedge clock);

      $display("covered %0d words: add %0d, remove %0d, refresh %0d,",
               DIR_ROWS + CHUNKS * CHUNK_WORDS, op_count[OP_ADD], op_count[OP_REMOVE],
               op_count[OP_REFRESH]);
      $display("  check %0d, lookup %0d, spare %0d; %0d full refusals, %0d expiries",
               op_count[OP_CHECK], op_count[OP_LOOKUP],
               op_count[5] + op_count[6] + op_count[7], full_seen, expired_seen);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
